// ===== hw/rtl/scaq_pkg.sv =====
// ----------------------------------------------------------------------------
// scaq_pkg: shared types and constants
// Action codes, command beat layout and back-end states for the selector
// channel queue arbiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scaq_pkg;

    localparam int ACTION_W    = 2;
    localparam int CH_SEL_W    = 2;
    localparam int REQ_W       = 4;
    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [CH_SEL_W-1:0] CHAN_MAP_MASK = 2'h3;

    localparam logic EV_START     = 1'b0;
    localparam logic EV_INTERRUPT = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_REQUEST   = 2'd0,
        ACT_FREE      = 2'd1,
        ACT_INTERRUPT = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_FREE,
        OP_INTERRUPT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [CH_SEL_W-1:0] ch;
        logic [REQ_W-1:0]    who;
        logic [BYTE_W-1:0]   addr;
        logic [BYTE_W-1:0]   status;
    } cmd_t;

    typedef enum logic {
        BK_EXEC,
        BK_FETCH
    } back_state_t;

endpackage

// ===== hw/rtl/scaq_front.sv =====
// ----------------------------------------------------------------------------
// scaq_front: action decode
// Checks channel and requester ranges, maps interrupts to a channel and
// forwards surviving beats as commands; everything else is absorbed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scaq_front #(
    parameter int CHANNELS   = 2,
    parameter int REQUESTERS = 16
) (
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [scaq_pkg::ACTION_W-1:0] s_action,
    input  logic                         s_channel,
    input  logic [scaq_pkg::REQ_W-1:0]   s_requester,
    input  logic [scaq_pkg::BYTE_W-1:0]  s_device_address,
    input  logic [scaq_pkg::BYTE_W-1:0]  s_interrupt_status,
    output logic                         push_valid,
    input  logic                         push_ready,
    output scaq_pkg::cmd_t               push_cmd
);
    import scaq_pkg::*;

    logic                keep;
    logic [CH_SEL_W-1:0] map_ch;

    assign map_ch  = s_device_address[CH_SEL_W-1:0] & CHAN_MAP_MASK;
    assign s_ready = push_ready;

    always_comb begin
        keep            = 1'b0;
        push_cmd.op     = OP_REQUEST;
        push_cmd.ch     = {1'b0, s_channel};
        push_cmd.who    = s_requester;
        push_cmd.addr   = s_device_address;
        push_cmd.status = s_interrupt_status;
        case (action_t'(s_action))
            ACT_REQUEST: begin
                keep = (int'(s_channel) < CHANNELS) && (int'(s_requester) < REQUESTERS);
            end
            ACT_FREE: begin
                push_cmd.op = OP_FREE;
                keep        = int'(s_channel) < CHANNELS;
            end
            ACT_INTERRUPT: begin
                push_cmd.op = OP_INTERRUPT;
                push_cmd.ch = map_ch;
                keep        = int'(map_ch) < CHANNELS;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign push_valid = s_valid && keep;

endmodule

// ===== hw/rtl/scaq_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// scaq_cmd_queue: command queue
// Two-entry queue between decode and execution.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scaq_cmd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  scaq_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output scaq_pkg::cmd_t out_cmd
);
    import scaq_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push, pop;

    assign in_ready  = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0
                                                                 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0
                                                                 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== hw/rtl/scaq_back.sv =====
// ----------------------------------------------------------------------------
// scaq_back: queue execution
// Holds per-channel pointers, counts, membership and owner, the slot
// memory and the output register; runs one command at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scaq_back #(
    parameter int CHANNELS   = 2,
    parameter int REQUESTERS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  scaq_pkg::cmd_t              cmd,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_event_kind,
    output logic [scaq_pkg::REQ_W-1:0]  m_target,
    output logic [scaq_pkg::BYTE_W-1:0] m_event_address,
    output logic [scaq_pkg::BYTE_W-1:0] m_event_status
);
    import scaq_pkg::*;

    localparam int CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RW        = $clog2(REQUESTERS);
    localparam int CNW       = $clog2(REQUESTERS + 1);
    localparam int MEM_DEPTH = CHANNELS * REQUESTERS;
    localparam int AW        = $clog2(MEM_DEPTH);

    logic [REQ_W-1:0]      slot_mem [MEM_DEPTH];
    logic [REQ_W-1:0]      rdata_reg;
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;

    logic [RW-1:0]         head_reg   [CHANNELS];
    logic [RW-1:0]         head_next  [CHANNELS];
    logic [RW-1:0]         tail_reg   [CHANNELS];
    logic [RW-1:0]         tail_next  [CHANNELS];
    logic [CNW-1:0]        count_reg  [CHANNELS];
    logic [CNW-1:0]        count_next [CHANNELS];
    logic [REQUESTERS-1:0] member_reg [CHANNELS];
    logic [REQUESTERS-1:0] member_next[CHANNELS];
    logic [REQ_W-1:0]      owner_reg  [CHANNELS];
    logic [REQ_W-1:0]      owner_next [CHANNELS];

    back_state_t           state_reg, state_next;
    logic [CW-1:0]         fetch_ch_reg, fetch_ch_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_kind_reg, out_kind_next;
    logic [REQ_W-1:0]      out_target_reg, out_target_next;
    logic [BYTE_W-1:0]     out_addr_reg, out_addr_next;
    logic [BYTE_W-1:0]     out_status_reg, out_status_next;

    logic                  out_free;
    logic                  take;

    function automatic logic [RW-1:0] ptr_inc(input logic [RW-1:0] p);
        return (p == RW'(REQUESTERS - 1)) ? '0 : p + RW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_addr(input logic [CW-1:0] c, input logic [RW-1:0] p);
        return AW'(c) * AW'(REQUESTERS) + AW'(p);
    endfunction

    assign out_free  = !out_valid_reg || m_ready;
    assign cmd_ready = (state_reg == BK_EXEC) && out_free;
    assign take      = cmd_valid && cmd_ready;

    assign m_valid         = out_valid_reg;
    assign m_event_kind    = out_kind_reg;
    assign m_target        = out_target_reg;
    assign m_event_address = out_addr_reg;
    assign m_event_status  = out_status_reg;

    always_comb begin
        logic [CW-1:0] ci;
        logic [RW-1:0] wi;
        logic [RW-1:0] h_nx;
        ci              = CW'(cmd.ch);
        wi              = RW'(cmd.who);
        h_nx            = ptr_inc(head_reg[ci]);
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        member_next     = member_reg;
        owner_next      = owner_reg;
        state_next      = state_reg;
        fetch_ch_next   = fetch_ch_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_kind_next   = out_kind_reg;
        out_target_next = out_target_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot_addr(ci, tail_reg[ci]);
        mem_re          = 1'b0;
        mem_raddr       = slot_addr(ci, h_nx);
        case (state_reg)
            BK_EXEC: begin
                if (take) begin
                    case (cmd.op)
                        OP_REQUEST: begin
                            if (!member_reg[ci][wi]) begin
                                mem_we              = 1'b1;
                                tail_next[ci]       = ptr_inc(tail_reg[ci]);
                                count_next[ci]      = count_reg[ci] + CNW'(1);
                                member_next[ci][wi] = 1'b1;
                                if (count_reg[ci] == '0) begin
                                    owner_next[ci]  = cmd.who;
                                    out_valid_next  = 1'b1;
                                    out_kind_next   = EV_START;
                                    out_target_next = cmd.who;
                                    out_addr_next   = '0;
                                    out_status_next = '0;
                                end
                            end
                        end
                        OP_FREE: begin
                            if (count_reg[ci] != '0) begin
                                member_next[ci][RW'(owner_reg[ci])] = 1'b0;
                                head_next[ci]  = h_nx;
                                count_next[ci] = count_reg[ci] - CNW'(1);
                                if (count_reg[ci] != CNW'(1)) begin
                                    mem_re        = 1'b1;
                                    fetch_ch_next = ci;
                                    state_next    = BK_FETCH;
                                end
                            end
                        end
                        OP_INTERRUPT: begin
                            if (count_reg[ci] != '0) begin
                                out_valid_next  = 1'b1;
                                out_kind_next   = EV_INTERRUPT;
                                out_target_next = owner_reg[ci];
                                out_addr_next   = cmd.addr;
                                out_status_next = cmd.status;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_FETCH: begin
                owner_next[fetch_ch_reg] = rdata_reg;
                out_valid_next           = 1'b1;
                out_kind_next            = EV_START;
                out_target_next          = rdata_reg;
                out_addr_next            = '0;
                out_status_next          = '0;
                state_next               = BK_EXEC;
            end
            default: begin
                state_next = BK_EXEC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                head_reg[i]   <= '0;
                tail_reg[i]   <= '0;
                count_reg[i]  <= '0;
                member_reg[i] <= '0;
            end
            state_reg     <= BK_EXEC;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            member_reg    <= member_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        owner_reg      <= owner_next;
        fetch_ch_reg   <= fetch_ch_next;
        out_kind_reg   <= out_kind_next;
        out_target_reg <= out_target_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= cmd.who;
        end
        if (mem_re) begin
            rdata_reg <= slot_mem[mem_raddr];
        end
    end

endmodule

// ===== hw/rtl/selector_channel_queue_arbiter.sv =====
// ----------------------------------------------------------------------------
// selector_channel_queue_arbiter: per-channel FIFO arbiter
// Input channel s_*: one action beat (request, free, interrupt) per
// handshake. Result channel m_*: start or interrupt-delivery events, zero
// or one per action. Beats that cause no event are absorbed silently.
// Decode feeds a two-entry command queue; the back end executes one command
// per cycle unless m_ready stalls or a slot fetch holds it, against
// per-channel head/tail pointers, counts, membership bits, registered owners.
// Path: a request or interrupt event passes the command queue and the
// output register to m_*; a free that hands the channel to a waiting
// requester also passes the registered read of the slot memory.
// Throughput: one beat per cycle while m_* does not stall, except a free
// with a successor, which holds the back end in its fetch state.
// Reset: all queues empty, no owners, output register empty; the slot
// memory needs no clearing.
// A stall on m_ready holds the event in the output register; the command
// queue keeps accepting until it fills, then s_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module selector_channel_queue_arbiter #(
    parameter int CHANNELS   = 2,
    parameter int REQUESTERS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [scaq_pkg::ACTION_W-1:0] s_action,
    input  logic                          s_channel,
    input  logic [scaq_pkg::REQ_W-1:0]    s_requester,
    input  logic [scaq_pkg::BYTE_W-1:0]   s_device_address,
    input  logic [scaq_pkg::BYTE_W-1:0]   s_interrupt_status,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_event_kind,
    output logic [scaq_pkg::REQ_W-1:0]    m_target,
    output logic [scaq_pkg::BYTE_W-1:0]   m_event_address,
    output logic [scaq_pkg::BYTE_W-1:0]   m_event_status
);
    import scaq_pkg::*;

    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic pop_valid, pop_ready;
    cmd_t pop_cmd;

    scaq_front #(
        .CHANNELS  (CHANNELS),
        .REQUESTERS(REQUESTERS)
    ) u_front (
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_channel         (s_channel),
        .s_requester       (s_requester),
        .s_device_address  (s_device_address),
        .s_interrupt_status(s_interrupt_status),
        .push_valid        (push_valid),
        .push_ready        (push_ready),
        .push_cmd          (push_cmd)
    );

    scaq_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (push_valid),
        .in_ready (push_ready),
        .in_cmd   (push_cmd),
        .out_valid(pop_valid),
        .out_ready(pop_ready),
        .out_cmd  (pop_cmd)
    );

    scaq_back #(
        .CHANNELS  (CHANNELS),
        .REQUESTERS(REQUESTERS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (pop_valid),
        .cmd_ready      (pop_ready),
        .cmd            (pop_cmd),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_target       (m_target),
        .m_event_address(m_event_address),
        .m_event_status (m_event_status)
    );

endmodule
